// File: src/twrtc_pkg.sv
// Package for the three-wire RTC burst master.
// Holds the phase enum, item kind and register index codes, and link constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twrtc_pkg;

   localparam int BYTE_W  = 8;
   localparam int TIME_W  = 56;
   localparam int WAIT_W  = 8;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_EN_WAIT  = 4'd1,
      PH_WR_SETUP = 4'd2,
      PH_WR_HIGH  = 4'd3,
      PH_WR_LOW   = 4'd4,
      PH_RD_HIGH  = 4'd5,
      PH_RD_LOW   = 4'd6,
      PH_DIS_WAIT = 4'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2
   } kind_type;

   typedef enum logic {
      CSR_HALF_PERIOD  = 1'b0,
      CSR_ENABLE_GUARD = 1'b1
   } csr_index_type;

   localparam logic [BYTE_W-1:0] CMD_BURST_READ  = 8'hBF;
   localparam logic [BYTE_W-1:0] CMD_BURST_WRITE = 8'hBE;
   localparam logic [BYTE_W-1:0] CMD_WP_REG      = 8'h8E;
   localparam logic [BYTE_W-1:0] BYTE_ZERO       = 8'h00;
   localparam logic [BYTE_W-1:0] SECONDS_MASK    = 8'h7F;
   localparam logic [WAIT_W-1:0] WAIT_ONE        = 8'h01;

   localparam logic [WAIT_W-1:0] HALF_PERIOD_RESET  = 8'd2;
   localparam logic [WAIT_W-1:0] ENABLE_GUARD_RESET = 8'd4;

endpackage

`default_nettype wire

// File: src/three_wire_rtc_burst_master.sv
// Top level of the three-wire RTC burst master: item pipeline and link sequencer.
// Depends on twrtc_pkg.
//
// Every req item (a tick or a start command) advances the link by one step.
// The block takes one item per clock while req is not stalled and answers each
// with exactly one rsp item, held first in the input register and then in the
// result register, with the whole sequencer update done in between. A stalled
// rsp holds the result register and back-pressures req only when both registers
// are full. The user writes half_period_ticks and enable_guard_ticks over the
// csr port only while no sequence runs (unenforced); a value of zero acts as one.
`timescale 1ns / 1ps
`default_nettype none

module three_wire_rtc_burst_master (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_kind,
   input  wire logic [twrtc_pkg::TIME_W-1:0] req_time_bytes,
   input  wire logic                         req_data_pin_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_clock_pin,
   output logic                              rsp_data_pin_out,
   output logic                              rsp_data_pin_drive,
   output logic                              rsp_enable_pin,
   output logic                              rsp_busy_res,
   output logic                              rsp_done_res,
   output logic                              rsp_rejected,
   output logic [twrtc_pkg::TIME_W-1:0]      rsp_read_bytes,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic                         csr_index,
   input  wire logic [twrtc_pkg::BYTE_W-1:0] csr_data
);
   import twrtc_pkg::*;

   // csr registers
   logic [WAIT_W-1:0] half_ff, guard_ff;
   logic [WAIT_W-1:0] half_ticks, guard_ticks;

   // input register
   logic              s1_valid_ff;
   logic [1:0]        s1_kind_ff;
   logic [TIME_W-1:0] s1_time_ff;
   logic              s1_din_ff;

   // sequencer state
   phase_type         phase_ff, phase_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [2:0]        bitp_ff, bitp_in;
   logic [3:0]        bytep_ff, bytep_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic [TIME_W-1:0] wbuf_ff, wbuf_in;
   logic [TIME_W-1:0] rbuf_ff, rbuf_in;
   logic              clk_ff, clk_in, dat_ff, dat_in, drv_ff, drv_in, en_ff, en_in;
   logic              opw_ff, opw_in;
   logic              done_in, rej_in;

   // byte start helpers
   logic              start_byte;
   logic [3:0]        nb;
   logic [3:0]        wb_off, rd_off;
   logic [BYTE_W-1:0] send_byte;
   logic              is_start;

   // result register
   logic              rsp_valid_ff;
   logic              advance, step;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff  <= HALF_PERIOD_RESET;
         guard_ff <= ENABLE_GUARD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_HALF_PERIOD:  half_ff  <= csr_data;
            CSR_ENABLE_GUARD: guard_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign half_ticks  = (half_ff == '0) ? WAIT_ONE : half_ff;
   assign guard_ticks = (guard_ff == '0) ? WAIT_ONE : guard_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_kind_ff <= req_kind;
         s1_time_ff <= req_time_bytes;
         s1_din_ff  <= req_data_pin_in;
      end
   end

   assign is_start = (s1_kind_ff == KIND_READ) || (s1_kind_ff == KIND_WRITE);

   always_comb begin
      wb_off = nb - 4'd3;
      if (!opw_ff) begin
         send_byte = CMD_BURST_READ;
      end else if (nb == 4'd0) begin
         send_byte = CMD_WP_REG;
      end else if (nb == 4'd2) begin
         send_byte = CMD_BURST_WRITE;
      end else if (nb >= 4'd3 && nb <= 4'd9) begin
         send_byte = wbuf_ff[wb_off[2:0]*BYTE_W +: BYTE_W];
      end else begin
         send_byte = BYTE_ZERO;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      bitp_in    = bitp_ff;
      bytep_in   = bytep_ff;
      shift_in   = shift_ff;
      wbuf_in    = wbuf_ff;
      rbuf_in    = rbuf_ff;
      clk_in     = clk_ff;
      dat_in     = dat_ff;
      drv_in     = drv_ff;
      en_in      = en_ff;
      opw_in     = opw_ff;
      done_in    = 1'b0;
      rej_in     = 1'b0;
      start_byte = 1'b0;
      nb         = bytep_ff;
      rd_off     = bytep_ff - 4'd1;

      if (phase_ff == PH_IDLE) begin
         if (is_start) begin
            opw_in = (s1_kind_ff == KIND_WRITE);
            if (s1_kind_ff == KIND_WRITE) begin
               wbuf_in = {s1_time_ff[TIME_W-1:BYTE_W], s1_time_ff[BYTE_W-1:0] & SECONDS_MASK};
            end
            bytep_in = '0;
            bitp_in  = '0;
            clk_in   = 1'b0;
            dat_in   = 1'b0;
            drv_in   = 1'b1;
            en_in    = 1'b1;
            phase_in = PH_EN_WAIT;
            wait_in  = guard_ticks;
         end
      end else begin
         rej_in = is_start;
         if (wait_ff > WAIT_ONE) begin
            wait_in = wait_ff - WAIT_ONE;
         end else begin
            case (phase_ff)
               PH_EN_WAIT: begin
                  start_byte = 1'b1;
               end
               PH_WR_SETUP: begin
                  clk_in   = 1'b1;
                  phase_in = PH_WR_HIGH;
                  wait_in  = half_ticks;
               end
               PH_WR_HIGH, PH_RD_HIGH: begin
                  clk_in   = 1'b0;
                  phase_in = (phase_ff == PH_WR_HIGH) ? PH_WR_LOW : PH_RD_LOW;
                  wait_in  = half_ticks;
               end
               PH_WR_LOW, PH_RD_LOW: begin
                  if (bitp_ff == 3'd7) begin
                     if (!opw_ff && bytep_ff >= 4'd1 && bytep_ff <= 4'd7) begin
                        rbuf_in[rd_off[2:0]*BYTE_W +: BYTE_W] = shift_ff;
                     end
                     bytep_in = bytep_ff + 4'd1;
                     if ((!opw_ff && bytep_ff >= 4'd7) ||
                         (opw_ff && (bytep_ff == 4'd1 || bytep_ff >= 4'd10))) begin
                        clk_in   = 1'b0;
                        en_in    = 1'b0;
                        phase_in = PH_DIS_WAIT;
                        wait_in  = guard_ticks;
                     end else begin
                        nb         = bytep_ff + 4'd1;
                        start_byte = 1'b1;
                     end
                  end else begin
                     bitp_in = bitp_ff + 3'd1;
                     wait_in = half_ticks;
                     if (phase_ff == PH_RD_LOW) begin
                        shift_in[bitp_in] = shift_ff[bitp_in] | s1_din_ff;
                        clk_in   = 1'b1;
                        phase_in = PH_RD_HIGH;
                     end else begin
                        dat_in   = shift_ff[bitp_in];
                        clk_in   = 1'b0;
                        phase_in = PH_WR_SETUP;
                     end
                  end
               end
               PH_DIS_WAIT: begin
                  if (opw_ff && bytep_ff == 4'd2) begin
                     en_in    = 1'b1;
                     phase_in = PH_EN_WAIT;
                     wait_in  = guard_ticks;
                  end else begin
                     phase_in = PH_IDLE;
                     wait_in  = '0;
                     done_in  = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  wait_in  = '0;
               end
            endcase
         end
      end

      if (start_byte) begin
         bitp_in = '0;
         wait_in = half_ticks;
         if (!opw_ff && nb >= 4'd1) begin
            drv_in   = 1'b0;
            shift_in = {{(BYTE_W-1){1'b0}}, s1_din_ff};
            clk_in   = 1'b1;
            phase_in = PH_RD_HIGH;
         end else begin
            drv_in   = 1'b1;
            shift_in = send_byte;
            dat_in   = send_byte[0];
            clk_in   = 1'b0;
            phase_in = PH_WR_SETUP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wait_ff  <= '0;
         bitp_ff  <= '0;
         bytep_ff <= '0;
         shift_ff <= '0;
         wbuf_ff  <= '0;
         rbuf_ff  <= '0;
         clk_ff   <= 1'b0;
         dat_ff   <= 1'b0;
         drv_ff   <= 1'b1;
         en_ff    <= 1'b0;
         opw_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         bitp_ff  <= bitp_in;
         bytep_ff <= bytep_in;
         shift_ff <= shift_in;
         wbuf_ff  <= wbuf_in;
         rbuf_ff  <= rbuf_in;
         clk_ff   <= clk_in;
         dat_ff   <= dat_in;
         drv_ff   <= drv_in;
         en_ff    <= en_in;
         opw_ff   <= opw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_clock_pin      <= clk_in;
         rsp_data_pin_out   <= dat_in;
         rsp_data_pin_drive <= drv_in;
         rsp_enable_pin     <= en_in;
         rsp_busy_res       <= (phase_in != PH_IDLE);
         rsp_done_res       <= done_in;
         rsp_rejected       <= rej_in;
         rsp_read_bytes     <= rbuf_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: src/twrtc_checker.sv
// Port-level checker for three_wire_rtc_burst_master, bound to the top level.
// Depends on twrtc_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

module twrtc_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic                         rsp_clock_pin,
   input wire logic                         rsp_enable_pin,
   input wire logic                         rsp_busy_res,
   input wire logic                         rsp_done_res,
   input wire logic                         rsp_rejected,
   input wire logic [twrtc_pkg::TIME_W-1:0] rsp_read_bytes
);
   import twrtc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_bytes) && $stable(rsp_busy_res))
      else $error("rsp item changed while stalled");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_enable_pin)
      else $error("done item shows busy or enable high");

   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> !rsp_clock_pin && !rsp_enable_pin)
      else $error("idle item with clock or enable high");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected && !rsp_done_res |-> rsp_busy_res)
      else $error("rejected item while not busy");

endmodule

bind three_wire_rtc_burst_master twrtc_checker u_twrtc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_clock_pin  (rsp_clock_pin),
   .rsp_enable_pin (rsp_enable_pin),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_done_res   (rsp_done_res),
   .rsp_rejected   (rsp_rejected),
   .rsp_read_bytes (rsp_read_bytes)
);

`default_nettype wire
